// ===== rtl/core/framed_send_with_ack_retry_unit_macros.svh =====
// Assertion helpers shared by the framed sender.
// Both macros sample on the rising clock edge and are quiet while reset is high.
`ifndef FRAMED_SEND_WITH_ACK_RETRY_UNIT_MACROS_SVH
`define FRAMED_SEND_WITH_ACK_RETRY_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSWAR_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSWAR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/fswar_pkg.sv =====
package fswar_pkg;

   // Default bounds: the store holds MAX_PAYLOAD_DEF - 1 payload bytes; a reply of MAX_REPLY_DEF bytes fails.
   localparam int MAX_PAYLOAD_DEF = 253;
   localparam int MAX_REPLY_DEF   = 259;

   // Frame and reply bytes.
   localparam logic [7:0]  ETX_BYTE = 8'h03;
   localparam logic [7:0]  ACK_BYTE = 8'h06;
   localparam logic [15:0] ACK_LEN  = 16'd4;

   // Register reset values.
   localparam logic [15:0] TIMEOUT_RESET   = 16'd5000;
   localparam logic [2:0]  MAX_TRIES_RESET = 3'd3;

   // Widths of the configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TRIES = 2'd1;

   // Operation carried by each input item.
   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_SLOT = 2'd1,
      OP_RX   = 2'd2,
      OP_TICK = 2'd3
   } op_type;

   // Kind of a result item.
   typedef enum logic {
      KIND_TX   = 1'b0,
      KIND_DONE = 1'b1
   } kind_type;

   // Completion status.
   typedef enum logic [1:0] {
      ST_ACK      = 2'd0,
      ST_TOO_LONG = 2'd1,
      ST_FAILED   = 2'd2
   } status_type;

   // Phase of the send sequencer.
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_SEND = 2'd1,
      PH_RECV = 2'd2
   } phase_type;

endpackage

// ===== rtl/core/fswar_req_if.sv =====
interface fswar_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] data;
   logic       last;

   modport source (output valid, output op, output data, output last, input ready);
   modport sink   (input valid, input op, input data, input last, output ready);
endinterface

// ===== rtl/core/fswar_rsp_if.sv =====
interface fswar_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] tx_byte;
   logic [1:0] status;

   modport source (output valid, output kind, output tx_byte, output status, input ready);
   modport sink   (input valid, input kind, input tx_byte, input status, output ready);
endinterface

// ===== rtl/core/fswar_csr_if.sv =====
interface fswar_csr_if;
   import fswar_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/framed_send_with_ack_retry_unit.sv =====
// Channel    | Port    | Direction | Payload
// -----------+---------+-----------+-----------------------------------
// request    | req_if  | in        | op, data, last
// result     | rsp_if  | out       | kind, tx_byte, status
// registers  | csr_if  | in        | index, wdata (always ready)
//
// A new item is accepted every cycle unless a result is stalled in the output register.
// Results leave through a single output register in the cycle after the item.
// The request side stalls only while a result waits in that register.
// Payload bytes are read from the store one slot ahead, so no slot waits on it.
// Synchronous reset returns to idle with the register reset values.
`include "framed_send_with_ack_retry_unit_macros.svh"

module framed_send_with_ack_retry_unit #(
   parameter int MAX_PAYLOAD = fswar_pkg::MAX_PAYLOAD_DEF,
   parameter int MAX_REPLY   = fswar_pkg::MAX_REPLY_DEF
) (
   input logic         clock,
   input logic         reset,
   fswar_req_if.sink   req_if,
   fswar_rsp_if.source rsp_if,
   fswar_csr_if.sink   csr_if
);
   import fswar_pkg::*;

   localparam int LW = $clog2(MAX_PAYLOAD + 4);
   localparam int AW = $clog2(MAX_PAYLOAD);
   localparam int RW = $clog2(MAX_REPLY + 1);

   // Configuration registers.
   logic [15:0] timeout_ff;
   logic [2:0]  max_tries_ff;

   // Message and sequencer state.
   logic [7:0]    payload_mem_ff [MAX_PAYLOAD-1];
   logic [7:0]    rd_data_ff;
   phase_type     phase_ff, phase_in;
   logic [LW-1:0] load_count_ff, load_count_in;
   logic          too_long_ff, too_long_in;
   logic [7:0]    xor_ff, xor_in;
   logic [LW-1:0] tx_pos_ff, tx_pos_in;
   logic [2:0]    attempt_ff, attempt_in;
   logic [RW-1:0] rx_count_ff, rx_count_in;
   logic [7:0]    head_ff [4];
   logic [7:0]    head_in [4];
   logic [7:0]    head_new [4];
   logic [15:0]   idle_ff, idle_in;

   // Result register.
   logic       out_valid_ff, out_valid_in;
   kind_type   out_kind_ff, out_kind_in;
   logic [7:0] out_byte_ff, out_byte_in;
   status_type out_status_ff, out_status_in;

   // Decoded events of the current item.
   logic          req_fire;
   logic          do_load, store_ok, do_slot, slot_end, do_rx, do_tick;
   logic          rx_too_long, rx_etx, is_ack, attempt_fail, fail_final;
   logic          finish_ok, finish_long, load_done, finish;
   logic [RW-1:0] rx_inc;
   logic [15:0]   idle_inc;
   logic [2:0]    att_inc;
   logic [LW-1:0] len_w;
   logic [15:0]   len16;
   logic [7:0]    frame_byte;

   // Handshakes: a result register that is free or being emptied takes a new item.
   assign req_if.ready = !out_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         max_tries_ff <= MAX_TRIES_RESET;
      end else if (csr_if.valid) begin
         if (csr_if.index == CSR_TIMEOUT) begin
            timeout_ff <= csr_if.wdata;
         end else if (csr_if.index == CSR_MAX_TRIES) begin
            max_tries_ff <= csr_if.wdata[2:0];
         end
      end
   end

   // Header bytes of the reply as they stand after the current received byte.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         head_new[k] = head_ff[k];
      end
      if (rx_count_ff < RW'(4)) begin
         head_new[rx_count_ff[1:0]] = req_if.data;
      end
   end

   // Event decode shared by the sequencer and the datapath.
   always_comb begin
      rx_inc   = rx_count_ff + RW'(1);
      idle_inc = (idle_ff != 16'hFFFF) ? idle_ff + 16'd1 : idle_ff;
      att_inc  = attempt_ff + 3'd1;

      do_load  = req_fire && (req_if.op == OP_LOAD) && (phase_ff == PH_IDLE);
      store_ok = do_load && (load_count_ff < LW'(MAX_PAYLOAD - 1));
      do_slot  = req_fire && (req_if.op == OP_SLOT) && (phase_ff == PH_SEND);
      slot_end = do_slot && (tx_pos_ff >= load_count_ff + LW'(4));
      do_rx    = req_fire && (req_if.op == OP_RX) && (phase_ff == PH_RECV);
      do_tick  = req_fire && (req_if.op == OP_TICK) && (phase_ff == PH_RECV);

      rx_too_long = do_rx && (rx_inc >= RW'(MAX_REPLY));
      rx_etx      = do_rx && !rx_too_long && (req_if.data == ETX_BYTE);
      is_ack      = ({head_new[0], head_new[1]} == ACK_LEN) &&
                    (head_new[2] == head_new[3]) && (head_new[2] == ACK_BYTE);

      attempt_fail = rx_too_long || (rx_etx && !is_ack) ||
                     (do_tick && (idle_inc >= timeout_ff));
      fail_final   = attempt_fail && ((att_inc >= max_tries_ff) || (att_inc == 3'd0));
      finish_ok    = rx_etx && is_ack;
      finish_long  = do_load && req_if.last && (too_long_ff || !store_ok);
      load_done    = do_load && req_if.last && !finish_long;
      finish       = finish_ok || finish_long || fail_final;
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (load_done) begin
               phase_in = PH_SEND;
            end
         end
         PH_SEND: begin
            if (slot_end) begin
               phase_in = PH_RECV;
            end
         end
         PH_RECV: begin
            if (finish) begin
               phase_in = PH_IDLE;
            end else if (attempt_fail) begin
               phase_in = PH_SEND;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Frame byte for the current slot position.
   always_comb begin
      len_w = load_count_ff + LW'(1);
      len16 = 16'(len_w);
      if (tx_pos_ff == LW'(0)) begin
         frame_byte = len16[15:8];
      end else if (tx_pos_ff == LW'(1)) begin
         frame_byte = len16[7:0];
      end else if (tx_pos_ff <= load_count_ff + LW'(1)) begin
         frame_byte = rd_data_ff;
      end else if (tx_pos_ff == load_count_ff + LW'(2)) begin
         frame_byte = 8'h00;
      end else if (tx_pos_ff == load_count_ff + LW'(3)) begin
         frame_byte = xor_ff;
      end else begin
         frame_byte = ETX_BYTE;
      end
   end

   // Datapath and result outputs.
   always_comb begin
      load_count_in = load_count_ff;
      too_long_in   = too_long_ff;
      xor_in        = xor_ff;
      tx_pos_in     = tx_pos_ff;
      attempt_in    = attempt_ff;
      rx_count_in   = rx_count_ff;
      idle_in       = idle_ff;
      for (int k = 0; k < 4; k++) begin
         head_in[k] = head_ff[k];
      end

      // Message loading.
      if (store_ok) begin
         load_count_in = load_count_ff + LW'(1);
         xor_in        = xor_ff ^ req_if.data;
      end
      if (do_load && !store_ok) begin
         too_long_in = 1'b1;
      end
      if (load_done) begin
         tx_pos_in  = '0;
         attempt_in = 3'd0;
      end

      // Transmit slots.
      if (do_slot && !slot_end) begin
         tx_pos_in = tx_pos_ff + LW'(1);
      end
      if (slot_end) begin
         rx_count_in = '0;
         idle_in     = 16'd0;
         for (int k = 0; k < 4; k++) begin
            head_in[k] = 8'h00;
         end
      end

      // Reply collection and timeout.
      if (do_rx) begin
         rx_count_in = rx_inc;
         idle_in     = 16'd0;
         for (int k = 0; k < 4; k++) begin
            head_in[k] = head_new[k];
         end
      end
      if (do_tick) begin
         idle_in = idle_inc;
      end

      // A failed attempt that is not the last one starts the frame again.
      if (attempt_fail) begin
         attempt_in = att_inc;
         tx_pos_in  = '0;
      end

      // Completion clears the message.
      if (finish) begin
         load_count_in = '0;
         too_long_in   = 1'b0;
         xor_in        = 8'h00;
         tx_pos_in     = '0;
         attempt_in    = 3'd0;
      end

      // Result register.
      out_valid_in  = out_valid_ff && !rsp_if.ready;
      out_kind_in   = out_kind_ff;
      out_byte_in   = out_byte_ff;
      out_status_in = out_status_ff;
      if (do_slot) begin
         out_valid_in  = 1'b1;
         out_kind_in   = KIND_TX;
         out_byte_in   = frame_byte;
         out_status_in = ST_ACK;
      end else if (finish) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_DONE;
         out_byte_in  = 8'h00;
         if (finish_ok) begin
            out_status_in = ST_ACK;
         end else if (finish_long) begin
            out_status_in = ST_TOO_LONG;
         end else begin
            out_status_in = ST_FAILED;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         load_count_ff <= '0;
         too_long_ff   <= 1'b0;
         xor_ff        <= 8'h00;
         tx_pos_ff     <= '0;
         attempt_ff    <= 3'd0;
         rx_count_ff   <= '0;
         idle_ff       <= 16'd0;
         out_valid_ff  <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            head_ff[k] <= 8'h00;
         end
      end else begin
         phase_ff      <= phase_in;
         load_count_ff <= load_count_in;
         too_long_ff   <= too_long_in;
         xor_ff        <= xor_in;
         tx_pos_ff     <= tx_pos_in;
         attempt_ff    <= attempt_in;
         rx_count_ff   <= rx_count_in;
         idle_ff       <= idle_in;
         out_valid_ff  <= out_valid_in;
         for (int k = 0; k < 4; k++) begin
            head_ff[k] <= head_in[k];
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      out_kind_ff   <= out_kind_in;
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
   end

   // Payload store: written while loading, read one slot ahead while sending.
   always_ff @(posedge clock) begin
      if (store_ok) begin
         payload_mem_ff[load_count_ff[AW-1:0]] <= req_if.data;
      end
      if ((tx_pos_in >= LW'(2)) && (tx_pos_in <= load_count_ff + LW'(1))) begin
         rd_data_ff <= payload_mem_ff[AW'(tx_pos_in - LW'(2))];
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.kind    = out_kind_ff;
   assign rsp_if.tx_byte = out_byte_ff;
   assign rsp_if.status  = out_status_ff;

   // Checks on the sequencer and the result register.
   `FSWAR_ASSERT_NEXT(a_slot_gives_byte, do_slot, out_valid_ff && (out_kind_ff == KIND_TX), "slot item gave no transmit byte")
   `FSWAR_ASSERT_IMPLY(a_no_accept_on_stall, out_valid_ff && !rsp_if.ready, !req_fire, "item accepted while result stalled")
   `FSWAR_ASSERT_IMPLY(a_pos_in_frame, phase_ff == PH_SEND, tx_pos_ff <= load_count_ff + LW'(4), "slot position beyond frame end")
   `FSWAR_ASSERT_IMPLY(a_idle_no_attempts, phase_ff == PH_IDLE, attempt_ff == 3'd0, "attempt count kept while idle")
   `FSWAR_ASSERT_IMPLY(a_too_long_full, too_long_ff, load_count_ff == LW'(MAX_PAYLOAD - 1), "overflow flag set before store full")

endmodule

// ===== test/framed_send_with_ack_retry_unit_test.sv =====
module framed_send_with_ack_retry_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fswar_pkg::*;

   // One line event as it leaves the block.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] tx_byte;
      status_type status;
   } line_event_type;

   // One row of the opening script; pinned rows carry their result typed in.
   typedef struct packed {
      op_type         op;
      logic [7:0]     data;
      logic           last;
      bit             pinned;
      line_event_type want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   fswar_req_if req_ch();
   fswar_rsp_if rsp_ch();
   fswar_csr_if csr_ch();

   framed_send_with_ack_retry_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #5 clock = ~clock;

   // Opening script: stray operations while idle, a two-byte message holding
   // a zero byte and 0xFF, a load while busy, the whole frame, an ACK and a stray slot.
   script_row_type script [20] = '{
      '{OP_SLOT, 8'h5A, 1'b0, 1'b0, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_RX,   8'h03, 1'b0, 1'b0, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_TICK, 8'hFF, 1'b1, 1'b0, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_LOAD, 8'h00, 1'b0, 1'b0, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_LOAD, 8'hFF, 1'b1, 1'b0, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_SLOT, 8'hC3, 1'b0, 1'b1, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_LOAD, 8'h55, 1'b1, 1'b0, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_SLOT, 8'h00, 1'b1, 1'b1, '{KIND_TX, 8'h03, ST_ACK}},
      '{OP_SLOT, 8'hFF, 1'b0, 1'b1, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_SLOT, 8'h81, 1'b0, 1'b1, '{KIND_TX, 8'hFF, ST_ACK}},
      '{OP_SLOT, 8'h42, 1'b0, 1'b1, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_SLOT, 8'h24, 1'b0, 1'b1, '{KIND_TX, 8'hFF, ST_ACK}},
      '{OP_SLOT, 8'h18, 1'b0, 1'b1, '{KIND_TX, 8'h03, ST_ACK}},
      '{OP_RX,   8'h00, 1'b0, 1'b0, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_RX,   8'h04, 1'b1, 1'b0, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_RX,   8'h06, 1'b0, 1'b0, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_TICK, 8'h00, 1'b0, 1'b0, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_RX,   8'h06, 1'b0, 1'b0, '{KIND_TX, 8'h00, ST_ACK}},
      '{OP_RX,   8'h03, 1'b0, 1'b1, '{KIND_DONE, 8'h00, ST_ACK}},
      '{OP_SLOT, 8'hA5, 1'b1, 1'b0, '{KIND_TX, 8'h00, ST_ACK}}
   };

   // Predicted state of the sender.
   logic [7:0]  pay_mem [MAX_PAYLOAD_DEF];
   int unsigned load_cnt = 0;
   bit          too_long = 1'b0;
   logic [7:0]  run_xor = 8'h00;
   phase_type   m_phase = PH_IDLE;
   int unsigned tx_pos = 0;
   logic [2:0]  tries_used = 3'd0;
   int unsigned rx_cnt = 0;
   logic [7:0]  head [4] = '{default: 8'h00};
   int unsigned idle_cnt = 0;
   logic [15:0] cfg_timeout = TIMEOUT_RESET;
   logic [2:0]  cfg_tries = MAX_TRIES_RESET;

   // Line events still owed by the block, oldest first.
   line_event_type awaited [$];

   bit             pin_on = 1'b0;
   line_event_type pin_ev = '0;
   bit             calm = 1'b0;
   bit             long_reply_done = 1'b0;
   int             work_items = 0;
   int             items_taken = 0;
   int             results_seen = 0;
   int             wrong_count = 0;
   int             n_ack = 0;
   int             n_long = 0;
   int             n_failed = 0;

   // End of a send: drop the message and report its status.
   function automatic void close_send(input status_type st, output bit emits,
                                      output line_event_type ev);
      load_cnt   = 0;
      too_long   = 1'b0;
      run_xor    = 8'h00;
      tx_pos     = 0;
      tries_used = 3'd0;
      m_phase    = PH_IDLE;
      emits      = 1'b1;
      ev         = '{KIND_DONE, 8'h00, st};
   endfunction

   // A failed attempt either restarts the frame or gives up.
   function automatic void lose_attempt(output bit emits, output line_event_type ev);
      emits = 1'b0;
      ev = '0;
      tries_used = tries_used + 3'd1;
      if (tries_used >= cfg_tries || tries_used == 3'd0) begin
         close_send(ST_FAILED, emits, ev);
      end else begin
         m_phase = PH_SEND;
         tx_pos  = 0;
      end
   endfunction

   // Advances the predicted sender by one item and gives the line event it causes.
   function automatic void sender_step(input op_type op, input logic [7:0] d, input logic l,
                                       output bit emits, output line_event_type ev);
      logic [15:0] flen;
      logic [7:0]  b;
      emits = 1'b0;
      ev = '0;
      flen = 16'(load_cnt + 1);
      case (op)
         OP_LOAD: begin
            if (m_phase == PH_IDLE) begin
               if (load_cnt + 1 < MAX_PAYLOAD_DEF) begin
                  pay_mem[load_cnt] = d;
                  run_xor ^= d;
                  load_cnt++;
               end else begin
                  too_long = 1'b1;
               end
               if (l) begin
                  if (too_long) begin
                     close_send(ST_TOO_LONG, emits, ev);
                  end else begin
                     m_phase    = PH_SEND;
                     tx_pos     = 0;
                     tries_used = 3'd0;
                  end
               end
            end
         end
         OP_SLOT: begin
            if (m_phase == PH_SEND) begin
               // Length, payload with terminator, XOR, then ETX.
               if (tx_pos == 0) b = flen[15:8];
               else if (tx_pos == 1) b = flen[7:0];
               else if (tx_pos < 2 + flen)
                  b = (tx_pos - 2 < load_cnt) ? pay_mem[tx_pos - 2] : 8'h00;
               else if (tx_pos == 2 + flen) b = run_xor;
               else b = ETX_BYTE;
               if (tx_pos >= load_cnt + 4) begin
                  m_phase  = PH_RECV;
                  rx_cnt   = 0;
                  head     = '{default: 8'h00};
                  idle_cnt = 0;
               end else begin
                  tx_pos++;
               end
               emits = 1'b1;
               ev = '{KIND_TX, b, ST_ACK};
            end
         end
         OP_RX: begin
            if (m_phase == PH_RECV) begin
               idle_cnt = 0;
               if (rx_cnt < 4) head[rx_cnt] = d;
               rx_cnt++;
               if (rx_cnt >= MAX_REPLY_DEF) begin
                  lose_attempt(emits, ev);
               end else if (d == ETX_BYTE) begin
                  if ({head[0], head[1]} == ACK_LEN && head[2] == head[3] && head[2] == ACK_BYTE)
                     close_send(ST_ACK, emits, ev);
                  else
                     lose_attempt(emits, ev);
               end
            end
         end
         default: begin
            if (m_phase == PH_RECV) begin
               if (idle_cnt < 16'hFFFF) idle_cnt++;
               if (idle_cnt >= cfg_timeout) lose_attempt(emits, ev);
            end
         end
      endcase
   endfunction

   // Register writes, accepted items and line events, all sampled at the rising edge.
   always @(posedge clock) begin : scoreboard
      bit             made;
      line_event_type ev;
      line_event_type want;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_TIMEOUT:   cfg_timeout = csr_ch.wdata;
               CSR_MAX_TRIES: cfg_tries = csr_ch.wdata[2:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            items_taken++;
            sender_step(op_type'(req_ch.op), req_ch.data, req_ch.last, made, ev);
            if (pin_on) awaited.push_back(pin_ev);
            else if (made) awaited.push_back(ev);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (awaited.size() == 0) begin
               wrong_count++;
               if (wrong_count <= 10)
                  $display("%0t: unexpected line event kind %0d byte %02h status %0d", $realtime,
                           rsp_ch.kind, rsp_ch.tx_byte, rsp_ch.status);
            end else begin
               want = awaited.pop_front();
               if (rsp_ch.kind !== want.kind || rsp_ch.tx_byte !== want.tx_byte ||
                   rsp_ch.status !== want.status) begin
                  wrong_count++;
                  if (wrong_count <= 10)
                     $display("%0t: expected kind %0d byte %02h status %0d, got %0d %02h %0d",
                              $realtime, want.kind, want.tx_byte, want.status,
                              rsp_ch.kind, rsp_ch.tx_byte, rsp_ch.status);
               end
               if (want.kind == KIND_DONE) begin
                  if (want.status == ST_ACK) n_ack++;
                  else if (want.status == ST_TOO_LONG) n_long++;
                  else n_failed++;
               end
            end
         end
      end
   end

   // The receiver holds off in random bursts, except in the calm part of the run.
   always begin : result_stall
      @(negedge clock);
      if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_ch.ready <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      rsp_ch.ready <= 1'b1;
   end

   // Presents one item from a falling edge and returns at the falling edge after it is taken.
   task automatic send_item(input op_type op, input logic [7:0] d, input logic l,
                            input bit counted, input bit pinned = 1'b0,
                            input line_event_type want = '0);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      pin_on = pinned;
      pin_ev = want;
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.data  <= d;
      req_ch.last  <= l;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      if (counted) work_items++;
   endtask

   // An operation that the current phase ignores.
   task automatic send_stray();
      op_type op;
      do op = op_type'($urandom_range(0, 3));
      while ((m_phase == PH_IDLE && op == OP_LOAD) || (m_phase == PH_SEND && op == OP_SLOT) ||
             (m_phase == PH_RECV && (op == OP_RX || op == OP_TICK)));
      send_item(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
   endtask

   // A random byte other than ETX.
   function automatic logic [7:0] plain_byte();
      logic [7:0] v;
      v = 8'($urandom_range(0, 254));
      return (v >= ETX_BYTE) ? v + 8'd1 : v;
   endfunction

   // One reply attempt; bit 8 of a step marks a tick.
   task automatic run_reply();
      logic [8:0] steps [$];
      logic [7:0] hdr [4];
      int plan;
      int eff;
      eff = (cfg_timeout == 16'd0) ? 1 : int'(cfg_timeout);
      plan = $urandom_range(0, 38);
      if (plan == 38 && long_reply_done && $urandom_range(0, 2) != 0) plan = 0;
      if (!long_reply_done) plan = 38;
      if (plan >= 30 && plan < 38 && eff > 40) plan = plan - 30;
      hdr = '{8'h00, 8'h04, ACK_BYTE, ACK_BYTE};
      if (plan < 16) begin
         // Good ACK, sometimes with padding before the ETX.
         foreach (hdr[i]) steps.push_back({1'b0, hdr[i]});
         if (plan >= 12) repeat ($urandom_range(1, 4)) steps.push_back({1'b0, plain_byte()});
         steps.push_back({1'b0, ETX_BYTE});
      end else if (plan < 22) begin
         // One header byte spoilt.
         hdr[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
         foreach (hdr[i]) steps.push_back({1'b0, hdr[i]});
         steps.push_back({1'b0, ETX_BYTE});
      end else if (plan < 26) begin
         // Short reply: the missing header bytes read as zero.
         for (int i = 0; i < $urandom_range(0, 3); i++) steps.push_back({1'b0, hdr[i]});
         steps.push_back({1'b0, ETX_BYTE});
      end else if (plan < 30) begin
         repeat ($urandom_range(1, 10)) steps.push_back({1'b0, 8'($urandom_range(0, 255))});
         steps.push_back({1'b0, ETX_BYTE});
      end else if (plan < 38) begin
         // Timeout, perhaps after a byte or two.
         repeat ($urandom_range(0, 2)) steps.push_back({1'b0, plain_byte()});
         repeat (eff + 2) steps.push_back(9'h100);
      end else begin
         // Reply too long: the last byte fails the attempt whatever it is.
         long_reply_done = 1'b1;
         repeat (MAX_REPLY_DEF - 1) steps.push_back({1'b0, plain_byte()});
         steps.push_back({1'b0, 8'($urandom_range(0, 255))});
      end
      foreach (steps[i]) begin
         if (m_phase != PH_RECV) break;
         if ($urandom_range(0, 19) == 0) send_stray();
         if (!steps[i][8] && plan < 30 && $urandom_range(0, 7) == 0)
            send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
         if (m_phase != PH_RECV) break;
         if (steps[i][8])
            send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
         else
            send_item(OP_RX, steps[i][7:0], 1'($urandom_range(0, 1)), 1'b1);
      end
   endtask

   // Loads one message and carries it through every attempt to its status.
   task automatic run_message(input int forced);
      int n;
      int r;
      r = $urandom_range(0, 59);
      if (forced > 0) n = forced;
      else if (r == 0) n = $urandom_range(240, 262);
      else if (r < 8) n = 1;
      else n = $urandom_range(2, 14);
      if ($urandom_range(0, 7) == 0) send_stray();
      for (int k = 0; k < n; k++) send_item(OP_LOAD, 8'($urandom_range(0, 255)), k == n - 1, 1'b1);
      while (m_phase != PH_IDLE) begin
         if (m_phase == PH_RECV) run_reply();
         else if ($urandom_range(0, 15) == 0) send_stray();
         else send_item(OP_SLOT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end
   endtask

   // Lets the block go quiet before its registers change or the run ends.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (awaited.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [15:0] t_cfg;
      logic [2:0]  m_cfg;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op    = OP_LOAD;
      req_ch.data  = 8'h00;
      req_ch.last  = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_TIMEOUT;
      csr_ch.wdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i])
         send_item(script[i].op, script[i].data, script[i].last, 1'b1, script[i].pinned,
                   script[i].want);

      // Six register settings, the extremes among them; the last runs without idling.
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin t_cfg = TIMEOUT_RESET; m_cfg = MAX_TRIES_RESET; end
            1: begin t_cfg = 16'd0; m_cfg = 3'd1; end
            2: begin t_cfg = 16'hFFFF; m_cfg = 3'd7; end
            3: begin t_cfg = 16'd1; m_cfg = 3'd0; end
            4: begin t_cfg = 16'($urandom_range(2, 40)); m_cfg = 3'($urandom_range(2, 6)); end
            default: begin t_cfg = 16'd20; m_cfg = 3'd4; end
         endcase
         settle();
         csr_ch.valid <= 1'b1;
         csr_ch.index <= CSR_TIMEOUT;
         csr_ch.wdata <= t_cfg;
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
         @(negedge clock);
         csr_ch.index <= CSR_MAX_TRIES;
         csr_ch.wdata <= (16'($urandom_range(0, 8191)) << 3) | 16'(m_cfg);
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
         @(negedge clock);
         csr_ch.valid <= 1'b0;
         calm = (p == 5);
         if (p == 1) begin
            // First byte past the store, then the longest message that fits.
            run_message(MAX_PAYLOAD_DEF);
            run_message(MAX_PAYLOAD_DEF - 1);
         end
         while (work_items < 20 + (p + 1) * 238) run_message(0);
      end

      settle();
      repeat (6) @(negedge clock);
      $display("Ran %0d items through six register settings and checked %0d line events.",
               items_taken, results_seen);
      $display("Sends ended: %0d acknowledged, %0d too long, %0d failed after retries.",
               n_ack, n_long, n_failed);
      if (wrong_count == 0 && awaited.size() == 0) begin
         $display("framed_send_with_ack_retry_unit: match");
      end else begin
         $display("framed_send_with_ack_retry_unit: mismatch");
      end
      $finish;
   end

   // Hard limit on the run.
   initial begin : watchdog
      #100_000_000;
      $display("framed_send_with_ack_retry_unit: mismatch");
      $finish;
   end

endmodule
